// ===== src/button_debounce_hold_detect_assert.svh =====
// assertion macros for the button debounce and hold detect block
// used by the top level only, no other dependencies
`ifndef BUTTON_DEBOUNCE_HOLD_DETECT_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BDHD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdhd assertion failed");

// next-cycle implication, checked out of reset
`define BDHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdhd assertion failed");

`endif

// ===== src/bdhd_pkg.sv =====
// shared types and constants of the button debounce and hold detect block
// no dependencies
package bdhd_pkg;

    localparam int MAX_BUTTONS = 16;
    localparam int NUM_BUTTONS_DEF = 4;

    localparam logic [7:0]             POLL_THRESHOLD_RESET = 8'd1;
    localparam logic [MAX_BUTTONS-1:0] IDLE_LEVELS_RESET    = 16'h000C;
    localparam logic [7:0]             HOLD_LIMIT_RESET     = 8'd100;

    // configuration register indexes
    localparam logic [1:0] REG_POLL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_IDLE_LEVELS    = 2'd1;
    localparam logic [1:0] REG_HOLD_LIMIT     = 2'd2;

    typedef enum logic [1:0] {
        CHG_NONE     = 2'd0,
        CHG_PUSHED   = 2'd1,
        CHG_RELEASED = 2'd2
    } change_t;

    typedef enum logic [1:0] {
        HOLD_NONE    = 2'd0,
        HOLD_REACHED = 2'd1,
        HOLD_EARLY   = 2'd2
    } hold_t;

    // what one lane reports for the current tick
    typedef struct packed {
        logic stable;
        logic mark;
    } lane_stat_t;

endpackage

// ===== src/bdhd_lane.sv =====
// one debounce lane: mismatch counter, accepted level and change mark of a button
// depends on bdhd_pkg
module bdhd_lane #(
    parameter logic RESET_LEVEL = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic                  pin,
    input  logic [7:0]            threshold,
    input  logic                  clear,
    output bdhd_pkg::lane_stat_t  stat
);
    import bdhd_pkg::*;

    logic [7:0] cnt_reg, cnt_next;
    logic       stable_reg, stable_next;
    logic       mark_reg, mark_next;
    logic       differ;
    logic       flip;
    logic [7:0] cnt_inc;

    always_comb begin
        differ      = (pin != stable_reg);
        cnt_inc     = cnt_reg + 8'd1;
        flip        = differ && (cnt_inc >= threshold);
        stable_next = flip ? pin : stable_reg;
        cnt_next    = (differ && !flip) ? cnt_inc : 8'd0;
        mark_next   = (mark_reg | flip) & ~clear;
        stat.stable = stable_next;
        stat.mark   = mark_reg | flip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 8'd0;
            stable_reg <= RESET_LEVEL;
            mark_reg   <= 1'b0;
        end else if (take) begin
            cnt_reg    <= cnt_next;
            stable_reg <= stable_next;
            mark_reg   <= mark_next;
        end
    end

endmodule

// ===== src/bdhd_merge.sv =====
// merge stage: picks the watched lane, decodes the change and runs the hold counter
// depends on bdhd_pkg
module bdhd_merge #(
    parameter int NUM_BUTTONS = bdhd_pkg::NUM_BUTTONS_DEF,
    parameter int WATCH_W     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   take,
    input  logic [WATCH_W-1:0]                     watched,
    input  bdhd_pkg::lane_stat_t [NUM_BUTTONS-1:0] stats,
    input  logic [NUM_BUTTONS-1:0]                 idle_levels,
    input  logic [7:0]                             hold_limit,
    output logic [NUM_BUTTONS-1:0]                 clear,
    output bdhd_pkg::change_t                      change,
    output bdhd_pkg::hold_t                        status
);
    import bdhd_pkg::*;

    logic [7:0] hold_reg, hold_next;
    logic       hit;
    logic       same_as_idle;

    always_comb begin
        hit          = 1'b0;
        same_as_idle = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            clear[i] = 1'b0;
            if (watched == WATCH_W'(i)) begin
                hit          = stats[i].mark;
                same_as_idle = (stats[i].stable == idle_levels[i]);
                clear[i]     = take;
            end
        end

        if (!hit) begin
            change = CHG_NONE;
        end else if (same_as_idle) begin
            change = CHG_RELEASED;
        end else begin
            change = CHG_PUSHED;
        end

        status = HOLD_NONE;
        case (change)
            CHG_NONE: begin
                hold_next = hold_reg + 8'd1;
            end
            CHG_PUSHED: begin
                hold_next = 8'd0;
            end
            CHG_RELEASED: begin
                hold_next = hold_reg;
                status    = HOLD_EARLY;
            end
            default: begin
                hold_next = hold_reg;
            end
        endcase

        if (hold_next == hold_limit) begin
            status    = HOLD_REACHED;
            hold_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 8'd0;
        end else if (take) begin
            hold_reg <= hold_next;
        end
    end

endmodule

// ===== src/button_debounce_hold_detect.sv =====
// top level of the button debounce and hold detect block
// depends on bdhd_pkg, bdhd_lane, bdhd_merge and button_debounce_hold_detect_assert.svh
//
// Each input transfer is one poll tick carrying the raw level of every button pin and the
// index of one watched button. Every button has its own lane with an 8-bit mismatch counter:
// a level that differs from the accepted one for poll_threshold ticks in a row is taken over
// and sets that button's change mark (a threshold of zero acts as one). The merge stage reads
// and clears the watched button's mark and reports pushed or released against idle_levels,
// and runs a shared 8-bit hold counter that counts no-change ticks, is cleared by a push,
// is left alone by a release and wraps at 256. When it equals hold_limit the result shows
// hold reached and the counter clears; a release otherwise shows released early. An index
// at or above the button count reads as no change. Every tick gives exactly one result
// transfer. The block takes one tick per clock: all lanes and the hold counter update in the
// cycle of the transfer, and a two-entry output buffer (output register plus skid register)
// keeps s_tready high while one finished result waits, so a stalled result side costs no
// input cycle until the buffer is full; results leave from the output register.
// Configuration lives at byte addresses 0 (poll_threshold), 4 (idle_levels) and
// 8 (hold_limit); write it only while the block is idle. Rewriting idle_levels does not move
// the accepted levels, which start out equal to the reset value of idle_levels.
module button_debounce_hold_detect #(
    parameter int NUM_BUTTONS = bdhd_pkg::NUM_BUTTONS_DEF,
    parameter int WATCH_W     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
    parameter int S_DATA_W    = ((NUM_BUTTONS + WATCH_W + 7) / 8) * 8,
    parameter int M_DATA_W    = ((NUM_BUTTONS + 4 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // pin_levels, watched_button, zero fill
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // hold_status, change_event, debounced_levels, zero fill
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bdhd_pkg::*;

    `include "button_debounce_hold_detect_assert.svh"

    localparam int RES_W = NUM_BUTTONS + 4;

    // configuration registers
    logic [7:0]             poll_threshold_reg;
    logic [NUM_BUTTONS-1:0] idle_levels_reg;
    logic [7:0]             hold_limit_reg;
    logic                   cfg_write;
    logic [1:0]             cfg_index;

    // tick datapath
    logic                             take;
    logic [NUM_BUTTONS-1:0]           pin_levels;
    logic [WATCH_W-1:0]               watched_button;
    lane_stat_t [NUM_BUTTONS-1:0]     stats;
    logic [NUM_BUTTONS-1:0]           clear;
    logic [NUM_BUTTONS-1:0]           debounced;
    change_t                          change;
    hold_t                            status;
    logic [RES_W-1:0]                 result;

    // output buffer
    logic             m_valid_reg;
    logic [RES_W-1:0] m_data_reg;
    logic             skid_valid_reg;
    logic [RES_W-1:0] skid_data_reg;
    logic             out_free;

    // config port: always ready, write on the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_threshold_reg <= POLL_THRESHOLD_RESET;
            idle_levels_reg    <= IDLE_LEVELS_RESET[NUM_BUTTONS-1:0];
            hold_limit_reg     <= HOLD_LIMIT_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_POLL_THRESHOLD: poll_threshold_reg <= pwdata[7:0];
                REG_IDLE_LEVELS:    idle_levels_reg    <= pwdata[NUM_BUTTONS-1:0];
                REG_HOLD_LIMIT:     hold_limit_reg     <= pwdata[7:0];
                default:            ; // unmapped address, ignored
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_POLL_THRESHOLD: prdata = 32'(poll_threshold_reg);
            REG_IDLE_LEVELS:    prdata = 32'(idle_levels_reg);
            REG_HOLD_LIMIT:     prdata = 32'(hold_limit_reg);
            default:            prdata = 32'd0;
        endcase
    end

    // unpack the tick
    assign take           = s_tvalid && s_tready;
    assign pin_levels     = s_tdata[NUM_BUTTONS-1:0];
    assign watched_button = s_tdata[NUM_BUTTONS+WATCH_W-1:NUM_BUTTONS];

    // one debounce lane per button
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        bdhd_lane #(
            .RESET_LEVEL (IDLE_LEVELS_RESET[i])
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .take      (take),
            .pin       (pin_levels[i]),
            .threshold (poll_threshold_reg),
            .clear     (clear[i]),
            .stat      (stats[i])
        );
        assign debounced[i] = stats[i].stable;
    end

    // watched-button select and hold counter
    bdhd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .WATCH_W     (WATCH_W)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .watched     (watched_button),
        .stats       (stats),
        .idle_levels (idle_levels_reg),
        .hold_limit  (hold_limit_reg),
        .clear       (clear),
        .change      (change),
        .status      (status)
    );

    assign result = {debounced, change, status};

    // two-entry output buffer: skid takes a result while the output register is stalled
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (take) begin
                m_data_reg <= result;
            end
        end else if (take) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    // a filled skid entry always sits behind a valid output
    `BDHD_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, m_valid_reg)
    // a release always carries a hold status
    `BDHD_ASSERT_NOW(a_release_status, aclk, aresetn,
        m_valid_reg && (m_data_reg[3:2] == CHG_RELEASED), m_data_reg[1:0] != HOLD_NONE)
    // a push never reports released early
    `BDHD_ASSERT_NOW(a_push_status, aclk, aresetn,
        m_valid_reg && (m_data_reg[3:2] == CHG_PUSHED), m_data_reg[1:0] != HOLD_EARLY)
    // a transfer into a stalled output lands in the skid entry
    `BDHD_ASSERT_NEXT(a_stall_to_skid, aclk, aresetn, take && !out_free, skid_valid_reg)

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for button_debounce_hold_detect: poll ticks go in on the
// stream input, each result is checked against a cycle-free predictor of the debouncer
// depends on bdhd_pkg and the rtl of the block, nothing else
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bdhd_pkg::*;

    localparam int NUM_BTN = 4;
    // byte address with no register behind it, writes there must be dropped
    localparam logic [3:0] ADDR_UNUSED = 4'd12;
    // cycles allowed for outstanding results once the stimulus is done
    localparam int DRAIN_LIMIT = 5000;
    // input transfer to m_tvalid, plus margin
    localparam int END_SETTLE = 4;

    // expected content of one result transfer
    typedef struct {
        hold_t          status;
        change_t        change;
        logic [NUM_BTN-1:0] levels;
    } tick_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // pin_levels [3:0], watched_button [5:4], zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // hold_status [1:0], change_event [3:2], debounced_levels [7:4]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the configuration registers
    logic [7:0]         cfg_threshold;
    logic [NUM_BTN-1:0] cfg_idle;
    logic [7:0]         cfg_limit;

    // predictor copy of the block state
    logic [NUM_BTN-1:0] acc_levels;
    logic [7:0]         miss_cnt [NUM_BTN];
    logic [NUM_BTN-1:0] chg_marks;
    logic [7:0]         hold_count;

    tick_result_t expected_ticks [$];
    int           error_count;

    // idling controls shared between the stimulus and the result side
    bit src_idle_en;
    bit sink_idle_en;
    int sink_hold_len;

    button_debounce_hold_detect dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block locks up
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v,
                     got_v);
    endtask

    // ------------------------------------------------------------------
    // predictor: one poll tick in, one result out
    // ------------------------------------------------------------------
    function automatic tick_result_t debounce_tick(input logic [NUM_BTN-1:0] pins,
                                                   input logic [1:0] watch);
        tick_result_t r;
        int b;
        r.status = HOLD_NONE;
        r.change = CHG_NONE;
        // per-button mismatch counters, a threshold of zero accepts on the first poll
        for (b = 0; b < NUM_BTN; b++) begin
            if (pins[b] != acc_levels[b]) begin
                miss_cnt[b] = miss_cnt[b] + 8'd1;
                if (miss_cnt[b] >= cfg_threshold) begin
                    acc_levels[b] = pins[b];
                    chg_marks[b]  = 1'b1;
                    miss_cnt[b]   = 8'd0;
                end
            end else begin
                miss_cnt[b] = 8'd0;
            end
        end
        // read and clear the watched mark, direction judged against the current idle level
        if (chg_marks[watch]) begin
            chg_marks[watch] = 1'b0;
            r.change = (acc_levels[watch] == cfg_idle[watch]) ? CHG_RELEASED : CHG_PUSHED;
        end
        // shared hold counter: counts quiet ticks, push clears, release leaves it
        if (r.change == CHG_NONE)
            hold_count = hold_count + 8'd1;
        else if (r.change == CHG_RELEASED)
            r.status = HOLD_EARLY;
        else
            hold_count = 8'd0;
        // reaching the limit wins over released early
        if (hold_count == cfg_limit) begin
            r.status   = HOLD_REACHED;
            hold_count = 8'd0;
        end
        r.levels = acc_levels;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, with an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_len > 0) begin
                // long stall so the output buffer fills and s_tready drops
                n = sink_hold_len;
                sink_hold_len = 0;
                m_tready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result checker, each transfer against the oldest expectation
    always @(posedge aclk) begin
        tick_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("result with nothing expected", 0, m_tdata);
            end else begin
                exp_r = expected_ticks.pop_front();
                if (m_tdata[1:0] !== exp_r.status)
                    report_mismatch("hold_status", exp_r.status, m_tdata[1:0]);
                if (m_tdata[3:2] !== exp_r.change)
                    report_mismatch("change_event", exp_r.change, m_tdata[3:2]);
                if (m_tdata[7:4] !== exp_r.levels)
                    report_mismatch("debounced_levels", exp_r.levels, m_tdata[7:4]);
            end
        end
    end

    // ------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------

    // one poll tick on the input channel, prediction taken at the accepting edge
    task automatic send_tick(input logic [NUM_BTN-1:0] pins, input logic [1:0] watch);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, watch, pins};
        do @(posedge aclk); while (!s_tready);
        expected_ticks.push_back(debounce_tick(pins, watch));
        @(negedge aclk);
    endtask

    // sender pause: every result in before anything else happens
    task automatic wait_results_done();
        s_tvalid = 1'b0;
        while (expected_ticks.size() != 0) @(negedge aclk);
    endtask

    // one apb transfer, setup then access, register updated at the access edge
    task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) begin
            case (addr[3:2])
                REG_POLL_THRESHOLD: cfg_threshold = wdata[7:0];
                REG_IDLE_LEVELS:    cfg_idle      = wdata[NUM_BTN-1:0];
                REG_HOLD_LIMIT:     cfg_limit     = wdata[7:0];
                default:            ;   // no register there
            endcase
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read back all three registers and compare the implemented bits
    task automatic check_registers();
        logic [31:0] rd;
        apb_access(1'b0, {REG_POLL_THRESHOLD, 2'b00}, 32'd0, rd);
        if (rd[7:0] !== cfg_threshold)
            report_mismatch("poll_threshold readback", cfg_threshold, rd[7:0]);
        apb_access(1'b0, {REG_IDLE_LEVELS, 2'b00}, 32'd0, rd);
        if (rd[NUM_BTN-1:0] !== cfg_idle)
            report_mismatch("idle_levels readback", cfg_idle, rd[NUM_BTN-1:0]);
        apb_access(1'b0, {REG_HOLD_LIMIT, 2'b00}, 32'd0, rd);
        if (rd[7:0] !== cfg_limit)
            report_mismatch("hold_limit readback", cfg_limit, rd[7:0]);
    endtask

    // reprogram while idle: every result has arrived and every tick gives one
    task automatic set_config(input logic [7:0] thr, input logic [NUM_BTN-1:0] idle,
                              input logic [7:0] limit);
        logic [31:0] rd;
        wait_results_done();
        apb_access(1'b1, {REG_POLL_THRESHOLD, 2'b00}, {24'd0, thr}, rd);
        apb_access(1'b1, {REG_IDLE_LEVELS, 2'b00}, {28'd0, idle}, rd);
        apb_access(1'b1, {REG_HOLD_LIMIT, 2'b00}, {24'd0, limit}, rd);
        check_registers();
    endtask

    // press and release sequences with contact bounce and occasional line noise;
    // a fixed watch index keeps the others changing quietly so the hold counter runs
    task automatic press_sequence(input int n, input int watch_fixed, input int flip_odds,
                                  input bit noisy);
        logic [NUM_BTN-1:0] target;
        logic [NUM_BTN-1:0] pins;
        logic [NUM_BTN-1:0] flip_mask;
        logic [1:0]         w;
        int bounce_left;
        int b;
        int i;
        target      = acc_levels;
        flip_mask   = '0;
        bounce_left = 0;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(1, flip_odds) == 1) begin
                if (watch_fixed >= 0 && $urandom_range(0, 9) != 0)
                    b = (watch_fixed + $urandom_range(1, NUM_BTN - 1)) % NUM_BTN;
                else
                    b = $urandom_range(0, NUM_BTN - 1);
                flip_mask   = '0;
                flip_mask[b] = 1'b1;
                target      = target ^ flip_mask;
                bounce_left = $urandom_range(0, 4);
            end
            pins = target;
            if (bounce_left > 0) begin
                bounce_left--;
                if ($urandom_range(0, 1) == 1)
                    pins = pins ^ flip_mask;
            end else if (noisy && $urandom_range(0, 19) == 0) begin
                pins = NUM_BTN'($urandom);
            end
            w = (watch_fixed >= 0) ? 2'(watch_fixed) : 2'($urandom_range(0, NUM_BTN - 1));
            send_tick(pins, w);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values read back, a write to an empty address leaves everything alone
    task automatic test_register_access();
        logic [31:0] rd;
        check_registers();
        apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF, rd);
        check_registers();
    endtask

    // pushes and releases with the reset settings, all pins low and all high
    task automatic test_levels_and_events();
        int w;
        for (w = 0; w < NUM_BTN; w++)
            send_tick(4'hC, 2'(w));         // at rest, nothing moves
        send_tick(4'h0, 2'd2);              // buttons 2 and 3 pushed
        send_tick(4'h0, 2'd3);
        send_tick(4'hF, 2'd0);              // buttons 0 and 1 pushed, 2 and 3 released
        send_tick(4'hF, 2'd3);
        send_tick(4'hF, 2'd1);
        send_tick(4'hF, 2'd2);
    endtask

    // threshold zero behaves as one, threshold 255 blocks a single differing poll
    task automatic test_zero_threshold();
        set_config(8'd0, cfg_idle, cfg_limit);
        send_tick(4'h0, 2'd0);
        send_tick(4'h0, 2'd1);
        set_config(8'd255, cfg_idle, cfg_limit);
        send_tick(4'hF, 2'd0);
        send_tick(4'h0, 2'd0);
    endtask

    // new idle levels change the direction of later events, not the accepted levels
    task automatic test_idle_rewrite();
        set_config(8'd1, 4'hF, cfg_limit);
        send_tick(4'hF, 2'd0);              // all pins back to the new idle level
        send_tick(4'hF, 2'd3);
        set_config(8'd1, 4'h0, cfg_limit);
        send_tick(4'h0, 2'd0);
        send_tick(4'h0, 2'd3);
    endtask

    // a release when the counter already equals the limit reports hold reached
    task automatic test_release_at_limit();
        set_config(8'd1, 4'hF, 8'd100);
        send_tick(4'hE, 2'd0);              // button 0 stays down, the others go up
        send_tick(4'hE, 2'd0);
        send_tick(4'hE, 2'd0);
        set_config(8'd1, 4'hF, hold_count);
        send_tick(4'hF, 2'd0);
    endtask

    task automatic test_random_presses();
        set_config(8'd1, 4'hC, 8'd100);
        press_sequence(150, -1, 6, 1'b1);
        set_config(8'd3, 4'hF, 8'd5);
        press_sequence(200, -1, 8, 1'b1);
    endtask

    // quiet watched button, limit zero: the counter wraps from 255 to 0 and hits the limit
    task automatic test_hold_wrap();
        set_config(8'd0, 4'h0, 8'd0);
        press_sequence(350, 0, 12, 1'b0);
        // counter well above a small limit has to wrap before reporting
        set_config(cfg_threshold, cfg_idle, 8'd255);
        press_sequence(60, 1, 20, 1'b0);
        set_config(cfg_threshold, cfg_idle, hold_count - 8'd3);
        press_sequence(40, 1, 20, 1'b0);
    endtask

    // largest threshold needs long steady levels before anything is accepted
    task automatic test_slow_threshold();
        set_config(8'd255, 4'h5, 8'd255);
        press_sequence(350, 2, 300, 1'b0);
    endtask

    // receiver stalls for a long time while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        set_config(8'd2, 4'hA, 8'd20);
        src_idle_en   = 1'b0;
        sink_hold_len = 80;
        press_sequence(40, -1, 5, 1'b1);
        wait_results_done();
        src_idle_en = 1'b1;
        press_sequence(160, -1, 6, 1'b1);
    endtask

    // random settings, no idling on either side
    task automatic test_closing_run();
        set_config(8'($urandom_range(1, 6)), 4'($urandom), 8'($urandom));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        press_sequence(200, -1, 6, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count   = 0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        sink_hold_len = 0;

        // predictor reset state
        cfg_threshold = POLL_THRESHOLD_RESET;
        cfg_idle      = IDLE_LEVELS_RESET[NUM_BTN-1:0];
        cfg_limit     = HOLD_LIMIT_RESET;
        acc_levels    = IDLE_LEVELS_RESET[NUM_BTN-1:0];
        foreach (miss_cnt[i])
            miss_cnt[i] = 8'd0;
        chg_marks  = '0;
        hold_count = 8'd0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_register_access();
        test_levels_and_events();
        test_zero_threshold();
        test_idle_rewrite();
        test_release_at_limit();
        test_random_presses();
        test_hold_wrap();
        test_slow_threshold();
        test_backpressure();
        test_closing_run();

        // bounded wait for the last results, then let the pipeline settle
        s_tvalid = 1'b0;
        n = 0;
        while (expected_ticks.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge aclk);
            n++;
        end
        repeat (END_SETTLE) @(negedge aclk);
        if (expected_ticks.size() != 0)
            report_mismatch("results never delivered", 0, expected_ticks.size());

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bdhd_pkg.sv
src/bdhd_lane.sv
src/bdhd_merge.sv
src/button_debounce_hold_detect.sv
verif/testbench.sv
